>>> rtl/core/jffp_pkg.sv
// ----------------------------------------------------------------------------
// jffp_pkg
// Shared types and character codes for the fuse-map text parser.
// ----------------------------------------------------------------------------
package jffp_pkg;

  localparam logic [7:0] CH_STX   = 8'h02;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_Q     = 8'h51;

  // Feature-bit flag that marks the SPI port as disabled
  localparam int unsigned SPI_DIS_BIT = 6;

  typedef enum logic [3:0] {
    PH_STX     = 4'd0,
    PH_Q_STAR  = 4'd1,
    PH_Q_KEY   = 4'd2,
    PH_QUAL    = 4'd3,
    PH_DIGITS  = 4'd4,
    PH_L_KEY   = 4'd5,
    PH_L_STAR  = 4'd6,
    PH_ADDR    = 4'd7,
    PH_FUSE    = 4'd8,
    PH_E_KEY   = 4'd9,
    PH_E_STAR  = 4'd10,
    PH_FEAT    = 4'd11,
    PH_FEABITS = 4'd12,
    PH_DONE    = 4'd13,
    PH_ERR     = 4'd14
  } phase_t;

  typedef enum logic [2:0] {
    K_PAGE  = 3'd0,
    K_FROW  = 3'd1,
    K_FBITS = 3'd2,
    K_DONE  = 3'd3,
    K_FMT   = 3'd4,
    K_SPI   = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [3:0]  idx;
    logic        last;
  } result_t;

endpackage

>>> rtl/core/jffp_if.sv
// ----------------------------------------------------------------------------
// jffp channel interfaces
// Valid/ready channels for text characters in and parsed results out.
// ----------------------------------------------------------------------------
interface jffp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_file;

  modport source (output valid, output char_code, output end_of_file, input ready);
  modport sink   (input valid, input char_code, input end_of_file, output ready);
endinterface

interface jffp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [7:0] data_byte;
  logic [3:0] byte_index;
  logic       last_of_group;

  modport source (output valid, output result_kind, output data_byte,
                  output byte_index, output last_of_group, input ready);
  modport sink   (input valid, input result_kind, input data_byte,
                  input byte_index, input last_of_group, output ready);
endinterface

>>> rtl/core/jffp_parser.sv
// ----------------------------------------------------------------------------
// jffp_parser
// Parse state registers and the per-character step logic.
// ----------------------------------------------------------------------------
module jffp_parser #(
  parameter int unsigned PAGE_BYTES         = 16,
  parameter int unsigned FEATURE_ROW_BYTES  = 8,
  parameter int unsigned MAX_ADDRESS_DIGITS = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [7:0]        char_code,
  input  logic              end_of_file,
  output logic              res_vld,
  output jffp_pkg::result_t res
);
  import jffp_pkg::*;

  phase_t     phase_r,     phase_nxt;
  logic [7:0] shift_r,     shift_nxt;
  logic [3:0] bcnt_r,      bcnt_nxt;
  logic [3:0] addr_tot_r,  addr_tot_nxt;
  logic [3:0] addr_seen_r, addr_seen_nxt;
  logic [3:0] gcnt_r,      gcnt_nxt;

  logic       is_space;
  logic       is_bit;
  logic [7:0] shift_new;
  logic [3:0] bcnt_new;
  logic       byte_full;
  logic [4:0] gcnt_inc;
  logic [3:0] seen_inc;

  assign is_space  = (char_code <= CH_SPACE) || (char_code == CH_STAR);
  assign is_bit    = (char_code == CH_ZERO) || (char_code == CH_ONE);
  assign shift_new = {shift_r[6:0], char_code == CH_ONE};
  assign bcnt_new  = bcnt_r + 4'd1;
  assign byte_full = is_bit && (bcnt_new >= 4'd8);
  assign gcnt_inc  = {1'b0, gcnt_r} + 5'd1;
  assign seen_inc  = addr_seen_r + 4'd1;

  always_comb begin
    phase_nxt     = phase_r;
    shift_nxt     = shift_r;
    bcnt_nxt      = bcnt_r;
    addr_tot_nxt  = addr_tot_r;
    addr_seen_nxt = addr_seen_r;
    gcnt_nxt      = gcnt_r;
    res_vld       = 1'b0;
    res           = '{kind: K_FMT, data: 8'd0, idx: 4'd0, last: 1'b0};

    if (end_of_file) begin
      // re-arm for the next file
      phase_nxt     = PH_STX;
      shift_nxt     = 8'd0;
      bcnt_nxt      = 4'd0;
      addr_tot_nxt  = 4'd0;
      addr_seen_nxt = 4'd0;
      gcnt_nxt      = 4'd0;
      if (phase_r == PH_DONE) begin
        res_vld  = 1'b1;
        res.kind = K_DONE;
      end else if (phase_r != PH_ERR) begin
        res_vld  = 1'b1;
      end
    end else begin
      // shift in fuse characters inside the data groups
      if ((phase_r == PH_FUSE || phase_r == PH_FEAT || phase_r == PH_FEABITS) &&
          char_code != CH_STAR && is_bit) begin
        shift_nxt = shift_new;
        bcnt_nxt  = byte_full ? 4'd0 : bcnt_new;
      end
      case (phase_r)
        PH_STX: begin
          if (char_code == CH_STX) phase_nxt = PH_Q_STAR;
        end
        PH_Q_STAR: begin
          if (char_code == CH_STAR) phase_nxt = PH_Q_KEY;
        end
        PH_Q_KEY: begin
          if (!is_space) phase_nxt = (char_code == CH_Q) ? PH_QUAL : PH_Q_STAR;
        end
        PH_QUAL: begin
          if (char_code == CH_F) begin
            phase_nxt    = PH_DIGITS;
            addr_tot_nxt = 4'd0;
          end else begin
            phase_nxt = PH_Q_STAR;
          end
        end
        PH_DIGITS: begin
          if (char_code == CH_STAR) begin
            phase_nxt = PH_L_KEY;
          end else if (addr_tot_r >= 4'(MAX_ADDRESS_DIGITS)) begin
            phase_nxt = PH_ERR;
            res_vld   = 1'b1;
          end else begin
            addr_tot_nxt = addr_tot_r + 4'd1;
          end
        end
        PH_L_KEY: begin
          if (!is_space) begin
            if (char_code == CH_L) begin
              addr_seen_nxt = 4'd0;
              if (addr_tot_r == 4'd0) begin
                phase_nxt = PH_FUSE;
                shift_nxt = 8'd0;
                bcnt_nxt  = 4'd0;
                gcnt_nxt  = 4'd0;
              end else begin
                phase_nxt = PH_ADDR;
              end
            end else begin
              phase_nxt = PH_L_STAR;
            end
          end
        end
        PH_L_STAR: begin
          if (char_code == CH_STAR) phase_nxt = PH_L_KEY;
        end
        PH_ADDR: begin
          if (char_code != CH_ZERO) begin
            phase_nxt = PH_ERR;
            res_vld   = 1'b1;
          end else begin
            addr_seen_nxt = seen_inc;
            if (seen_inc >= addr_tot_r) begin
              phase_nxt = PH_FUSE;
              shift_nxt = 8'd0;
              bcnt_nxt  = 4'd0;
              gcnt_nxt  = 4'd0;
            end
          end
        end
        PH_FUSE: begin
          if (char_code == CH_STAR) begin
            if (gcnt_r != 4'd0) begin
              phase_nxt = PH_ERR;
              res_vld   = 1'b1;
            end else begin
              // end of fuse table: drop any partial byte
              phase_nxt = PH_E_KEY;
              shift_nxt = 8'd0;
              bcnt_nxt  = 4'd0;
            end
          end else if (byte_full) begin
            res_vld  = 1'b1;
            res.kind = K_PAGE;
            res.data = shift_new;
            res.idx  = gcnt_r;
            res.last = gcnt_inc >= 5'(PAGE_BYTES);
            gcnt_nxt = res.last ? 4'd0 : gcnt_inc[3:0];
          end
        end
        PH_E_KEY: begin
          if (!is_space) begin
            if (char_code == CH_E) begin
              phase_nxt = PH_FEAT;
              shift_nxt = 8'd0;
              bcnt_nxt  = 4'd0;
              gcnt_nxt  = 4'd0;
            end else begin
              phase_nxt = PH_E_STAR;
            end
          end
        end
        PH_E_STAR: begin
          if (char_code == CH_STAR) phase_nxt = PH_E_KEY;
        end
        PH_FEAT: begin
          if (char_code == CH_STAR) begin
            phase_nxt = PH_ERR;
            res_vld   = 1'b1;
          end else if (byte_full) begin
            res_vld  = 1'b1;
            res.kind = K_FROW;
            res.data = shift_new;
            res.idx  = gcnt_r;
            res.last = gcnt_inc >= 5'(FEATURE_ROW_BYTES);
            if (res.last) begin
              gcnt_nxt  = 4'd0;
              phase_nxt = PH_FEABITS;
            end else begin
              gcnt_nxt = gcnt_inc[3:0];
            end
          end
        end
        PH_FEABITS: begin
          if (char_code == CH_STAR) begin
            phase_nxt = PH_ERR;
            res_vld   = 1'b1;
          end else if (byte_full) begin
            res_vld  = 1'b1;
            res.kind = K_FBITS;
            res.data = shift_new;
            if (gcnt_r == 4'd0) begin
              gcnt_nxt = 4'd1;
            end else begin
              gcnt_nxt = 4'd0;
              res.idx  = 4'd1;
              res.last = 1'b1;
              if (shift_new[SPI_DIS_BIT]) begin
                res.kind  = K_SPI;
                phase_nxt = PH_ERR;
              end else begin
                phase_nxt = PH_DONE;
              end
            end
          end
        end
        default: begin
          // done and error: ignore characters until end of file
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_STX;
      shift_r     <= 8'd0;
      bcnt_r      <= 4'd0;
      addr_tot_r  <= 4'd0;
      addr_seen_r <= 4'd0;
      gcnt_r      <= 4'd0;
    end else if (adv) begin
      phase_r     <= phase_nxt;
      shift_r     <= shift_nxt;
      bcnt_r      <= bcnt_nxt;
      addr_tot_r  <= addr_tot_nxt;
      addr_seen_r <= addr_seen_nxt;
      gcnt_r      <= gcnt_nxt;
    end
  end

  a_spi_to_err: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_vld && res.kind == K_SPI |=> phase_r == PH_ERR)
    else $error("spi disabled result did not stop the parser");

  a_done_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_vld && res.kind == K_DONE |=> phase_r == PH_STX)
    else $error("finished result did not re-arm the parser");

  a_eof_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    adv && end_of_file |=> phase_r == PH_STX && bcnt_r == 4'd0 && gcnt_r == 4'd0)
    else $error("end of file did not clear parse state");

  a_bit_count: assert property (@(posedge clk) disable iff (!rst_n)
    bcnt_r < 4'd8)
    else $error("bit count out of range");

endmodule

>>> rtl/core/jffp_out_reg.sv
// ----------------------------------------------------------------------------
// jffp_out_reg
// Result register holding one parsed result until the sink takes it.
// ----------------------------------------------------------------------------
module jffp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  jffp_pkg::result_t res,
  output logic              space,
  jffp_out_if.source        out_ch
);
  import jffp_pkg::*;

  logic    vld_r;
  result_t res_r;

  // free when empty or being drained this cycle
  assign space = !vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid         = vld_r;
  assign out_ch.result_kind   = res_r.kind;
  assign out_ch.data_byte     = res_r.data;
  assign out_ch.byte_index    = res_r.idx;
  assign out_ch.last_of_group = res_r.last;

endmodule

>>> rtl/core/jedec_fuse_file_parser_unit.sv
// Each character is stepped from the input register; its result goes to the result register.
// Throughput: one character per cycle unless a result finds the result register full, set
//   by the single-pass step logic between the input register and the result register.
// A character that causes no result never waits on the output side.
// Reset (synchronous, rst_n low): parser waits for STX, counters clear,
//   both register stages empty.
// ----------------------------------------------------------------------------
// jedec_fuse_file_parser_unit
// Streaming fuse-map text parser: pages, feature row, feature bits and status out.
// ----------------------------------------------------------------------------
module jedec_fuse_file_parser_unit #(
  parameter int unsigned PAGE_BYTES         = 16,
  parameter int unsigned FEATURE_ROW_BYTES  = 8,
  parameter int unsigned MAX_ADDRESS_DIGITS = 15
) (
  input  logic       clk,
  input  logic       rst_n,
  jffp_in_if.sink    in_ch,
  jffp_out_if.source out_ch
);
  import jffp_pkg::*;

  logic       in_vld_r;
  logic [7:0] char_r;
  logic       eof_r;

  logic       adv;
  logic       res_vld;
  result_t    res;
  logic       space;

  // advance the held character unless its result has nowhere to go
  assign adv         = in_vld_r && (!res_vld || space);
  assign in_ch.ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      char_r <= in_ch.char_code;
      eof_r  <= in_ch.end_of_file;
    end
  end

  jffp_parser #(
    .PAGE_BYTES         (PAGE_BYTES),
    .FEATURE_ROW_BYTES  (FEATURE_ROW_BYTES),
    .MAX_ADDRESS_DIGITS (MAX_ADDRESS_DIGITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .char_code   (char_r),
    .end_of_file (eof_r),
    .res_vld     (res_vld),
    .res         (res)
  );

  jffp_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (adv && res_vld),
    .res    (res),
    .space  (space),
    .out_ch (out_ch)
  );

endmodule

>>> sim/tb_jedec_fuse_file_parser_unit.sv
// ----------------------------------------------------------------------------
// tb_jedec_fuse_file_parser_unit
// Self-checking bench for the fuse-map text parser. A short table of
// hand-picked characters opens the run, then randomly built fuse-map files,
// some well formed and most broken, stream through with bursty input and a
// stalling receiver. Every transaction on the result channel is checked field
// by field against a parser model kept inside the bench, or a pinned row's result.
// ----------------------------------------------------------------------------
module tb_jedec_fuse_file_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import jffp_pkg::*;

  localparam int unsigned PAGE_BYTES         = 16;
  localparam int unsigned FEATURE_ROW_BYTES  = 8;
  localparam int unsigned MAX_ADDRESS_DIGITS = 15;

  localparam int CHAR_TARGET  = 950;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 8;

  localparam result_t FMT_ERR = '{kind: K_FMT, data: 8'h00, idx: 4'h0, last: 1'b0};
  localparam result_t NO_RES  = '0;

  typedef enum int {
    FL_NONE,
    FL_TRUNC,
    FL_DIGITS,
    FL_ADDR,
    FL_STAR,
    FL_NOISY,
    FL_GARBAGE
  } file_fault_t;

  typedef struct {
    logic [7:0] c;
    logic       eof;
    bit         pin;
    bit         pin_got;
    result_t    pin_res;
  } stim_row_t;

  typedef struct {
    logic [7:0] c;
    logic       eof;
  } char_item_t;

  logic clk = 1'b0;
  logic rst_n;

  jffp_in_if  in_ch ();
  jffp_out_if out_ch ();

  jedec_fuse_file_parser_unit #(
    .PAGE_BYTES         (PAGE_BYTES),
    .FEATURE_ROW_BYTES  (FEATURE_ROW_BYTES),
    .MAX_ADDRESS_DIGITS (MAX_ADDRESS_DIGITS)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // Directed characters; pinned rows carry the result typed in by hand.
  stim_row_t dir_tab [29] = '{
    '{8'hFF,    1'b1, 1'b1, 1'b1, FMT_ERR},  // end of file while idle
    '{8'h00,    1'b0, 1'b0, 1'b0, NO_RES},
    '{8'hFF,    1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_STX,   1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_STAR,  1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_SPACE, 1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_Q,     1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h58,    1'b0, 1'b0, 1'b0, NO_RES},   // qualifier other than F
    '{CH_STAR,  1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_Q,     1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_STAR,  1'b0, 1'b0, 1'b0, NO_RES},   // qualifier is the delimiter
    '{CH_STAR,  1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_Q,     1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_F,     1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_ZERO,  1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_STAR,  1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_L,     1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_ONE,   1'b0, 1'b1, 1'b1, FMT_ERR},  // non-zero address digit
    '{CH_ZERO,  1'b0, 1'b0, 1'b0, NO_RES},   // dropped after the error
    '{8'h00,    1'b1, 1'b1, 1'b0, NO_RES},   // re-arm, silent
    '{CH_STX,   1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_STAR,  1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_Q,     1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_F,     1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_STAR,  1'b0, 1'b0, 1'b0, NO_RES},   // empty address
    '{CH_L,     1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_ONE,   1'b0, 1'b0, 1'b0, NO_RES},
    '{CH_STAR,  1'b0, 1'b0, 1'b0, NO_RES},   // table ends, partial byte lost
    '{8'hFF,    1'b1, 1'b1, 1'b1, FMT_ERR}   // end of file mid-parse
  };

  // Parser model state
  phase_t     ps_phase;
  logic [7:0] ps_shift;
  logic [3:0] ps_nbits;
  logic [3:0] ps_digits;
  logic [3:0] ps_zeros;
  logic [3:0] ps_bytes;
  logic       ps_fuse_taken;
  logic       ps_qf_seen;

  result_t    due_results [$];
  char_item_t file_q [$];

  logic    drv_pin;
  logic    drv_pin_got;
  result_t drv_pin_res;

  int burst_left;
  int chars_sent;
  int files_built;
  int results_checked;
  int mismatches;
  int cycle_cnt;
  int kind_seen [8];
  int star_at;
  int data_count;

  // ---------------------------------------------------------------- model
  function automatic void clear_parser();
    ps_phase      = PH_STX;
    ps_shift      = '0;
    ps_nbits      = '0;
    ps_digits     = '0;
    ps_zeros      = '0;
    ps_bytes      = '0;
    ps_fuse_taken = 1'b0;
    ps_qf_seen    = 1'b0;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return (c <= CH_SPACE) || (c == CH_STAR);
  endfunction

  function automatic void start_fuse();
    ps_phase      = PH_FUSE;
    ps_fuse_taken = 1'b1;
    ps_shift      = '0;
    ps_nbits      = '0;
    ps_bytes      = '0;
  endfunction

  // Shift in a '0'/'1' character; true once eight bits are in.
  function automatic bit shift_bit(input logic [7:0] c);
    if (c != CH_ZERO && c != CH_ONE) return 1'b0;
    ps_shift = {ps_shift[6:0], c == CH_ONE};
    ps_nbits = ps_nbits + 4'd1;
    if (ps_nbits >= 4'd8) begin
      ps_nbits = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void parse_char(input logic [7:0] c, input logic eof,
                                     output bit got, output result_t r);
    bit fmt;
    fmt = 1'b0;
    got = 1'b0;
    r   = '0;
    if (eof) begin
      got = (ps_phase != PH_ERR);
      r.kind = (ps_phase == PH_DONE) ? K_DONE : K_FMT;
      clear_parser();
      return;
    end
    case (ps_phase)
      PH_STX: if (c == CH_STX) ps_phase = PH_Q_STAR;
      PH_Q_STAR: if (c == CH_STAR) ps_phase = PH_Q_KEY;
      PH_Q_KEY: if (!is_blank(c)) ps_phase = (c == CH_Q) ? PH_QUAL : PH_Q_STAR;
      PH_QUAL: begin
        if (c == CH_F) begin
          ps_phase  = PH_DIGITS;
          ps_digits = '0;
        end else begin
          ps_phase = PH_Q_STAR;
        end
      end
      PH_DIGITS: begin
        if (c == CH_STAR) begin
          ps_qf_seen = 1'b1;
          ps_phase   = PH_L_KEY;
        end else if (ps_digits >= MAX_ADDRESS_DIGITS) begin
          fmt = 1'b1;
        end else begin
          ps_digits = ps_digits + 4'd1;
        end
      end
      PH_L_KEY: begin
        if (!is_blank(c)) begin
          if (c == CH_L) begin
            ps_zeros = '0;
            if (ps_digits == 0) start_fuse();
            else ps_phase = PH_ADDR;
          end else begin
            ps_phase = PH_L_STAR;
          end
        end
      end
      PH_L_STAR: if (c == CH_STAR) ps_phase = PH_L_KEY;
      PH_ADDR: begin
        if (c != CH_ZERO) begin
          fmt = 1'b1;
        end else begin
          ps_zeros = ps_zeros + 4'd1;
          if (ps_zeros >= ps_digits) start_fuse();
        end
      end
      PH_FUSE: begin
        if (c == CH_STAR) begin
          if (ps_bytes != 0) begin
            fmt = 1'b1;
          end else begin
            ps_phase = PH_E_KEY;
            ps_shift = '0;
            ps_nbits = '0;
          end
        end else if (shift_bit(c)) begin
          got      = 1'b1;
          r.kind   = K_PAGE;
          r.data   = ps_shift;
          r.idx    = ps_bytes;
          r.last   = (int'(ps_bytes) + 1 >= PAGE_BYTES);
          ps_bytes = r.last ? 4'd0 : ps_bytes + 4'd1;
        end
      end
      PH_E_KEY: begin
        if (!is_blank(c)) begin
          if (c == CH_E) begin
            ps_phase = PH_FEAT;
            ps_shift = '0;
            ps_nbits = '0;
            ps_bytes = '0;
          end else begin
            ps_phase = PH_E_STAR;
          end
        end
      end
      PH_E_STAR: if (c == CH_STAR) ps_phase = PH_E_KEY;
      PH_FEAT: begin
        if (c == CH_STAR) begin
          fmt = 1'b1;
        end else if (shift_bit(c)) begin
          got    = 1'b1;
          r.kind = K_FROW;
          r.data = ps_shift;
          r.idx  = ps_bytes;
          r.last = (int'(ps_bytes) + 1 >= FEATURE_ROW_BYTES);
          if (r.last) begin
            ps_bytes = '0;
            ps_phase = PH_FEABITS;
          end else begin
            ps_bytes = ps_bytes + 4'd1;
          end
        end
      end
      PH_FEABITS: begin
        if (c == CH_STAR) begin
          fmt = 1'b1;
        end else if (shift_bit(c)) begin
          got    = 1'b1;
          r.data = ps_shift;
          r.kind = K_FBITS;
          if (ps_bytes == 0) begin
            ps_bytes = 4'd1;
          end else begin
            ps_bytes = '0;
            r.idx    = 4'd1;
            r.last   = 1'b1;
            if (ps_shift[SPI_DIS_BIT]) begin
              r.kind   = K_SPI;
              ps_phase = PH_ERR;
            end else begin
              ps_phase = PH_DONE;
            end
          end
        end
      end
      default: ;
    endcase
    if (fmt) begin
      got      = 1'b1;
      r        = FMT_ERR;
      ps_phase = PH_ERR;
    end
  endfunction

  // ------------------------------------------------------ file generation
  function automatic void push_char(input logic [7:0] ch);
    file_q.push_back('{c: ch, eof: 1'b0});
  endfunction

  function automatic logic [7:0] any_but(input logic [7:0] avoid);
    logic [7:0] ch;
    do ch = 8'($urandom_range(0, 255)); while (ch == avoid);
    return ch;
  endfunction

  // Printable, never the delimiter.
  function automatic logic [7:0] pick_text(input logic [7:0] avoid);
    logic [7:0] ch;
    do ch = 8'($urandom_range(8'h21, 8'h7E)); while (ch == CH_STAR || ch == avoid);
    return ch;
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(0, 255));
    while (ch == CH_ZERO || ch == CH_ONE || ch == CH_STAR);
    return ch;
  endfunction

  function automatic void push_pad();
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 3) == 0) push_char(8'($urandom_range(0, CH_SPACE)));
      else push_char($urandom_range(0, 1) ? CH_SPACE : 8'h0A);
    end
  endfunction

  function automatic void push_note(input logic [7:0] avoid_key);
    push_pad();
    push_char(pick_text(avoid_key));
    repeat ($urandom_range(0, 4)) push_char(pick_text(CH_STAR));
    push_char(CH_STAR);
  endfunction

  function automatic void push_data_byte(input logic [7:0] b);
    if (data_count == star_at) push_char(CH_STAR);
    data_count++;
    for (int k = 7; k >= 0; k--) begin
      if ($urandom_range(0, 11) == 0) push_char(noise_char());
      push_char(b[k] ? CH_ONE : CH_ZERO);
    end
  endfunction

  function automatic file_fault_t pick_fault();
    int r;
    r = $urandom_range(0, 99);
    if (r < 34) return FL_NONE;
    if (r < 52) return FL_TRUNC;
    if (r < 62) return FL_DIGITS;
    if (r < 72) return FL_ADDR;
    if (r < 84) return FL_STAR;
    if (r < 93) return FL_NOISY;
    return FL_GARBAGE;
  endfunction

  task automatic build_file();
    file_fault_t fault;
    int          pages;
    int          digits;
    int          bad;
    int          cut;
    int          r;
    logic [7:0]  fb1;
    file_q.delete();
    files_built++;
    fault = pick_fault();
    if (fault == FL_GARBAGE) begin
      repeat ($urandom_range(8, 30))
        file_q.push_back('{c: 8'($urandom), eof: ($urandom_range(0, 7) == 0)});
      file_q.push_back('{c: 8'($urandom), eof: 1'b1});
      return;
    end
    repeat ($urandom_range(0, 3)) push_char(any_but(CH_STX));
    push_char(CH_STX);
    repeat ($urandom_range(0, 4)) push_char(pick_text(CH_STAR));
    push_char(CH_STAR);
    repeat ($urandom_range(0, 2)) push_note(CH_Q);
    push_pad();
    push_char(CH_Q);
    push_char(CH_F);
    digits = (fault == FL_DIGITS) ? 16 + $urandom_range(0, 2) : $urandom_range(0, 15);
    if (fault == FL_ADDR && digits == 0) digits = $urandom_range(1, 15);
    repeat (digits) begin
      if ($urandom_range(0, 3) == 0) push_char(any_but(CH_STAR));
      else push_char(8'(CH_ZERO + $urandom_range(0, 9)));
    end
    push_char(CH_STAR);
    repeat ($urandom_range(0, 1)) push_note(CH_L);
    push_pad();
    push_char(CH_L);
    bad = (fault == FL_ADDR) ? $urandom_range(0, digits - 1) : -1;
    for (int i = 0; i < digits && i < MAX_ADDRESS_DIGITS; i++)
      push_char((i == bad) ? any_but(CH_ZERO) : CH_ZERO);

    r = $urandom_range(0, 19);
    pages = (r < 10) ? 0 : (r < 17) ? 1 : 2;
    star_at = -1;
    if (fault == FL_STAR) begin
      star_at = $urandom_range(1, pages * 16 + 9);
      // a delimiter on a page boundary is legal, so step past it
      if (star_at < pages * 16 && star_at % 16 == 0) star_at++;
    end
    data_count = 0;
    repeat (pages * 16) push_data_byte(8'($urandom));
    // leftover bits of an unfinished byte get dropped by the delimiter
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 7)) push_char($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
    push_char(CH_STAR);
    repeat ($urandom_range(0, 1)) push_note(CH_E);
    push_pad();
    push_char(CH_E);
    repeat (FEATURE_ROW_BYTES + 1) push_data_byte(8'($urandom));
    fb1 = 8'($urandom);
    fb1[SPI_DIS_BIT] = ($urandom_range(0, 3) == 0);
    push_data_byte(fb1);
    push_char(CH_STAR);
    repeat ($urandom_range(0, 6)) push_char(8'($urandom));

    if (fault == FL_NOISY) begin
      foreach (file_q[i])
        if ($urandom_range(0, 24) == 0) file_q[i].c = 8'($urandom);
    end
    if (fault == FL_TRUNC) begin
      cut = $urandom_range(0, file_q.size() - 1);
      while (file_q.size() > cut) void'(file_q.pop_back());
    end
    file_q.push_back('{c: 8'($urandom), eof: 1'b1});
  endtask

  // --------------------------------------------------------------- driving
  task automatic send_char(input logic [7:0] ch, input logic eof,
                           input bit pin = 1'b0, input bit pin_got = 1'b0,
                           input result_t pin_res = '0);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_ch.valid       <= 1'b1;
    in_ch.char_code   <= ch;
    in_ch.end_of_file <= eof;
    drv_pin           <= pin;
    drv_pin_got       <= pin_got;
    drv_pin_res       <= pin_res;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    chars_sent++;
  endtask

  // Hold the input idle until every predicted result is out.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (due_results.size() != 0) @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] seen);
    mismatches++;
    if (mismatches <= 30)
      $display("MISMATCH cycle %0d: %s expected %h got %h", cycle_cnt, what, want, seen);
  endtask

  // ------------------------------------------------------------ scoreboard
  always @(posedge clk) begin : scoreboard
    bit      got;
    result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        parse_char(in_ch.char_code, in_ch.end_of_file, got, want);
        if (drv_pin) begin
          got  = drv_pin_got;
          want = drv_pin_res;
        end
        if (got) due_results.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        kind_seen[out_ch.result_kind]++;
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result, kind", 8'h00, {5'b0, out_ch.result_kind});
        end else begin
          want = due_results.pop_front();
          if (out_ch.result_kind !== want.kind)
            report_mismatch("result_kind", {5'b0, want.kind}, {5'b0, out_ch.result_kind});
          if (out_ch.data_byte !== want.data)
            report_mismatch("data_byte", want.data, out_ch.data_byte);
          if (out_ch.byte_index !== want.idx)
            report_mismatch("byte_index", {4'b0, want.idx}, {4'b0, out_ch.byte_index});
          if (out_ch.last_of_group !== want.last)
            report_mismatch("last_of_group", {7'b0, want.last}, {7'b0, out_ch.last_of_group});
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, due_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver back-pressure: switch between a few stall patterns.
  initial begin : sink_stall
    int mode;
    int span;
    int k;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      for (k = 0; k < span; k++) begin
        @(negedge clk);
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= (k % 5 == 4);
        endcase
      end
    end
  end

  // -------------------------------------------------------------- stimulus
  initial begin : stimulus
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.char_code   = '0;
    in_ch.end_of_file = 1'b0;
    drv_pin           = 1'b0;
    drv_pin_got       = 1'b0;
    drv_pin_res       = '0;
    clear_parser();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i])
      send_char(dir_tab[i].c, dir_tab[i].eof, dir_tab[i].pin,
                dir_tab[i].pin_got, dir_tab[i].pin_res);

    wait_drained();
    while (chars_sent < CHAR_TARGET) begin
      build_file();
      if ($urandom_range(0, 7) == 0) wait_drained();
      foreach (file_q[i]) send_char(file_q[i].c, file_q[i].eof);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d characters in %0d random files plus a directed table",
             chars_sent, files_built);
    $display("Checked %0d results: page %0d, row %0d, bits %0d, done %0d, fmt %0d, spi %0d",
             results_checked, kind_seen[K_PAGE], kind_seen[K_FROW], kind_seen[K_FBITS],
             kind_seen[K_DONE], kind_seen[K_FMT], kind_seen[K_SPI]);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
